// ===== hw/rtl/iopfc_pkg.sv =====
`timescale 1ns / 1ps

package iopfc_pkg;

   // Command codes carried by an input word
   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_TRIGGER = 2'd1,
      CMD_REFRESH = 2'd2,
      CMD_MANUAL  = 2'd3
   } cmd_type;

   // Output pin function codes; 5 to 7 are unused: a refresh leaves such a pin as it is
   localparam logic [2:0] FN_NONE      = 3'd0;
   localparam logic [2:0] FN_FAULT     = 3'd1;
   localparam logic [2:0] FN_ON_COUPLE = 3'd2;
   localparam logic [2:0] FN_TRIGGER   = 3'd3;
   localparam logic [2:0] FN_MANUAL    = 3'd4;

   // Input pin function codes
   localparam logic IN_FN_NONE    = 1'b0;
   localparam logic IN_FN_INHIBIT = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_IN_FUNCTION   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IN_POLARITY   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT1_FUNCTION = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT1_POLARITY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT2_FUNCTION = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT2_POLARITY = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PULSE_WIDTH   = 3'd6;

   localparam int unsigned CSR_DATA_W = 31;
   localparam logic [CSR_DATA_W-1:0] PULSE_WIDTH_RESET = 31'd5000;

   // Stored status codes: 0/1 known, 2 unknown
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

endpackage

// ===== hw/rtl/io_pin_function_controller_top.sv =====
`timescale 1ns / 1ps

// A word accepted on req_ passes the input register, then the result register, and is
// presented on rsp_; it waits in the input register while the result is stalled.
// Throughput: one word per cycle unless rsp_ready stalls; the tick path is one 32-bit
// subtract and compare. Reset (synchronous, active high) empties both stages,
// restores register defaults and sets the stored fault and enable status to unknown.
module io_pin_function_controller_top
   import iopfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input word channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_cmd,
   input  logic [31:0]            req_now_us,
   input  logic                   req_ext_trig_level,
   input  logic                   req_any_fault,
   input  logic                   req_any_output_enabled,
   input  logic                   req_pin_select,
   input  logic                   req_pin_value,
   // result word channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_dout1_level,
   output logic                   rsp_dout2_level,
   output logic                   rsp_inhibit_active,
   output logic                   rsp_inhibit_changed,
   output logic                   rsp_manual_state1,
   output logic                   rsp_manual_state2,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers
   logic                  in_function_ff;
   logic                  in_polarity_ff;
   logic [2:0]            out_fn_ff [2];
   logic                  out_pol_ff [2];
   logic [CSR_DATA_W-1:0] pulse_width_ff;

   // pin state
   logic [1:0]  last_fault_ff, last_fault_in;
   logic [1:0]  last_enabled_ff, last_enabled_in;
   logic        pulse_active_ff, pulse_active_in;
   logic [31:0] pulse_start_ff, pulse_start_in;
   logic        inhibit_state_ff, inhibit_state_in;
   logic        pin_levels_ff [2];
   logic        pin_levels_in [2];
   logic        manual_ff [2];
   logic        manual_in [2];
   logic        changed_in;

   // input stage
   logic        s1_valid_ff;
   cmd_type     s1_cmd_ff;
   logic [31:0] s1_now_ff;
   logic        s1_ext_ff;
   logic        s1_fault_ff;
   logic        s1_enabled_ff;
   logic        s1_sel_ff;
   logic        s1_val_ff;

   // result stage
   logic rsp_valid_ff;
   logic rsp_dout1_ff;
   logic rsp_dout2_ff;
   logic rsp_inhibit_ff;
   logic rsp_changed_ff;
   logic rsp_manual1_ff;
   logic rsp_manual2_ff;

   logic        s1_fire;
   logic        req_fire;
   logic        inh;
   logic [31:0] elapsed;
   logic        expired;
   logic        need_f;
   logic        need_e;
   logic        ch_f;
   logic        ch_e;

   // handshake: result register frees when empty or taken
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_function_ff <= IN_FN_NONE;
         in_polarity_ff <= 1'b0;
         out_fn_ff[0]   <= FN_NONE;
         out_fn_ff[1]   <= FN_NONE;
         out_pol_ff[0]  <= 1'b0;
         out_pol_ff[1]  <= 1'b0;
         pulse_width_ff <= PULSE_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IN_FUNCTION:   in_function_ff <= csr_data[0];
            REG_IN_POLARITY:   in_polarity_ff <= csr_data[0];
            REG_OUT1_FUNCTION: out_fn_ff[0]   <= csr_data[2:0];
            REG_OUT1_POLARITY: out_pol_ff[0]  <= csr_data[0];
            REG_OUT2_FUNCTION: out_fn_ff[1]   <= csr_data[2:0];
            REG_OUT2_POLARITY: out_pol_ff[1]  <= csr_data[0];
            REG_PULSE_WIDTH:   pulse_width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff     <= cmd_type'(req_cmd);
         s1_now_ff     <= req_now_us;
         s1_ext_ff     <= req_ext_trig_level;
         s1_fault_ff   <= req_any_fault;
         s1_enabled_ff <= req_any_output_enabled;
         s1_sel_ff     <= req_pin_select;
         s1_val_ff     <= req_pin_value;
      end
   end

   // pulse timeout: signed elapsed time must be non-negative and past the width
   assign elapsed = s1_now_ff - pulse_start_ff;
   assign expired = pulse_active_ff && !elapsed[31] && (elapsed[30:0] > pulse_width_ff);

   assign inh    = (in_function_ff == IN_FN_INHIBIT) ? (s1_ext_ff ^ in_polarity_ff) : 1'b0;
   assign need_f = (out_fn_ff[0] == FN_FAULT) || (out_fn_ff[1] == FN_FAULT);
   assign need_e = (out_fn_ff[0] == FN_ON_COUPLE) || (out_fn_ff[1] == FN_ON_COUPLE);
   assign ch_f   = need_f && (last_fault_ff != {1'b0, s1_fault_ff});
   assign ch_e   = need_e && (last_enabled_ff != {1'b0, s1_enabled_ff});

   // next pin state for the word in the input register
   always_comb begin
      last_fault_in    = last_fault_ff;
      last_enabled_in  = last_enabled_ff;
      pulse_active_in  = pulse_active_ff;
      pulse_start_in   = pulse_start_ff;
      inhibit_state_in = inhibit_state_ff;
      pin_levels_in    = pin_levels_ff;
      manual_in        = manual_ff;
      changed_in       = 1'b0;
      case (s1_cmd_ff)
         CMD_TICK: begin
            inhibit_state_in = inh;
            changed_in       = (inh != inhibit_state_ff);
            if (expired) begin
               pulse_active_in = 1'b0;
               for (int k = 0; k < 2; k++) begin
                  if (out_fn_ff[k] == FN_TRIGGER) begin
                     pin_levels_in[k] = out_pol_ff[k];
                  end
               end
            end
            if (ch_f) begin
               last_fault_in = {1'b0, s1_fault_ff};
            end
            if (ch_e) begin
               last_enabled_in = {1'b0, s1_enabled_ff};
            end
            for (int k = 0; k < 2; k++) begin
               if (out_fn_ff[k] == FN_FAULT && ch_f) begin
                  pin_levels_in[k] = s1_fault_ff ^ out_pol_ff[k];
               end else if (out_fn_ff[k] == FN_ON_COUPLE && ch_e) begin
                  pin_levels_in[k] = s1_enabled_ff ^ out_pol_ff[k];
               end
            end
         end
         CMD_TRIGGER: begin
            for (int k = 0; k < 2; k++) begin
               if (out_fn_ff[k] == FN_TRIGGER) begin
                  pin_levels_in[k] = ~out_pol_ff[k];
                  pulse_active_in  = 1'b1;
                  pulse_start_in   = s1_now_ff;
               end
            end
         end
         CMD_REFRESH: begin
            // unknown status counts as asserted
            for (int k = 0; k < 2; k++) begin
               if (out_fn_ff[k] == FN_NONE) begin
                  pin_levels_in[k] = 1'b0;
               end else if (out_fn_ff[k] == FN_FAULT) begin
                  pin_levels_in[k] = (|last_fault_ff) ^ out_pol_ff[k];
               end else if (out_fn_ff[k] == FN_ON_COUPLE) begin
                  pin_levels_in[k] = (|last_enabled_ff) ^ out_pol_ff[k];
               end
            end
         end
         CMD_MANUAL: begin
            manual_in[s1_sel_ff]     = s1_val_ff;
            pin_levels_in[s1_sel_ff] = s1_val_ff ^ out_pol_ff[s1_sel_ff];
         end
         default: ;
      endcase
   end

   // state commit, in word order
   always_ff @(posedge clock) begin
      if (reset) begin
         last_fault_ff    <= STATUS_UNKNOWN;
         last_enabled_ff  <= STATUS_UNKNOWN;
         pulse_active_ff  <= 1'b0;
         pulse_start_ff   <= '0;
         inhibit_state_ff <= 1'b0;
         pin_levels_ff[0] <= 1'b0;
         pin_levels_ff[1] <= 1'b0;
         manual_ff[0]     <= 1'b0;
         manual_ff[1]     <= 1'b0;
      end else if (s1_fire) begin
         last_fault_ff    <= last_fault_in;
         last_enabled_ff  <= last_enabled_in;
         pulse_active_ff  <= pulse_active_in;
         pulse_start_ff   <= pulse_start_in;
         inhibit_state_ff <= inhibit_state_in;
         pin_levels_ff    <= pin_levels_in;
         manual_ff        <= manual_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_dout1_ff   <= pin_levels_in[0];
         rsp_dout2_ff   <= pin_levels_in[1];
         rsp_inhibit_ff <= inhibit_state_in;
         rsp_changed_ff <= changed_in;
         rsp_manual1_ff <= manual_in[0];
         rsp_manual2_ff <= manual_in[1];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_dout1_level     = rsp_dout1_ff;
   assign rsp_dout2_level     = rsp_dout2_ff;
   assign rsp_inhibit_active  = rsp_inhibit_ff;
   assign rsp_inhibit_changed = rsp_changed_ff;
   assign rsp_manual_state1   = rsp_manual1_ff;
   assign rsp_manual_state2   = rsp_manual2_ff;

`ifndef SYNTHESIS
   // only a tick can report an inhibit change
   a_changed_only_tick: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_cmd_ff != CMD_TICK |=> !rsp_changed_ff)
      else $error("inhibit change reported on a non-tick word");

   // a stalled result blocks the input stage once it is full
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input accepted while both stages are blocked");

   // stored status never takes the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      last_fault_ff != 2'd3 && last_enabled_ff != 2'd3)
      else $error("stored status holds an illegal code");

   // a pulse starts only from a trigger word
   a_pulse_start: assert property (@(posedge clock) disable iff (reset)
      $rose(pulse_active_ff) |-> $past(s1_fire && s1_cmd_ff == CMD_TRIGGER))
      else $error("pulse started without a trigger");

   // without the inhibit function a tick leaves inhibit inactive
   a_inhibit_off: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_cmd_ff == CMD_TICK && in_function_ff == IN_FN_NONE
      |=> !inhibit_state_ff)
      else $error("inhibit active with no inhibit function");
`endif

endmodule
